FILE: design/dehs_pkg.sv
// ----------------------------------------------------------------------------
// dehs_pkg
// types and constants shared by the drive enable and homing sequencer
// ----------------------------------------------------------------------------
package dehs_pkg;

	// sequencer steps
	typedef enum logic [3:0] {
		ST_IDLE     = 4'd0,
		ST_CW134    = 4'd1,
		ST_FR_READY = 4'd2,
		ST_MODE_MSG = 4'd3,
		ST_MODE_CHG = 4'd4,
		ST_CW7      = 4'd5,
		ST_CW15     = 4'd6,
		ST_CW31     = 4'd7,
		ST_HOME     = 4'd8
	} step_t;

	// request being served
	typedef enum logic [1:0] {
		REQ_NONE     = 2'd0,
		REQ_FAULT    = 2'd1,
		REQ_HOMING   = 2'd2,
		REQ_POSITION = 2'd3
	} req_t;

	// what one item does to the sequence
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_FINISH,
		ACT_SEND_CW,
		ACT_ENTER_MODE,
		ACT_FR_READY,
		ACT_MODE_CMD,
		ACT_HOME_WAIT
	} act_t;

	// item op codes
	localparam logic [2:0] OP_TICK        = 3'd0;
	localparam logic [2:0] OP_STATUS      = 3'd1;
	localparam logic [2:0] OP_MODE        = 3'd2;
	localparam logic [2:0] OP_FAULT_RESET = 3'd3;
	localparam logic [2:0] OP_HOMING      = 3'd4;
	localparam logic [2:0] OP_POSITION    = 3'd5;

	// decoded drive states
	localparam logic [3:0] DS_NOT_READY  = 4'd0;
	localparam logic [3:0] DS_DISABLED   = 4'd1;
	localparam logic [3:0] DS_READY      = 4'd2;
	localparam logic [3:0] DS_ON         = 4'd3;
	localparam logic [3:0] DS_ENABLED    = 4'd4;
	localparam logic [3:0] DS_QUICKSTOP  = 4'd5;
	localparam logic [3:0] DS_FAULT_REAC = 4'd6;
	localparam logic [3:0] DS_FAULT      = 4'd7;
	localparam logic [3:0] DS_UNDEFINED  = 4'd8;

	// status word decode masks and patterns
	localparam logic [15:0] SW_MASK_A      = 16'b0000_0000_0100_1111;
	localparam logic [15:0] SW_MASK_B      = 16'b0000_0000_0110_1111;
	localparam logic [15:0] SW_NOT_READY   = 16'h0000;
	localparam logic [15:0] SW_DISABLED    = 16'h0040;
	localparam logic [15:0] SW_READY       = 16'b0000_0000_0010_0001;
	localparam logic [15:0] SW_ON          = 16'h0023;
	localparam logic [15:0] SW_ENABLED     = 16'h0027;
	localparam logic [15:0] SW_QUICKSTOP   = 16'h0007;
	localparam logic [15:0] SW_FAULT_REAC  = 16'h000F;
	localparam logic [15:0] SW_FAULT       = 16'b0000_0000_0000_1000;
	localparam logic [15:0] SW_HOME_DONE   = 16'b0001_0000_0000_0000;
	localparam logic [15:0] SW_HOME_ERROR  = 16'b0010_0000_0000_0000;

	// control words
	localparam logic [15:0] CW_FAULT_RESET = 16'd134;
	localparam logic [15:0] CW_SWITCH_ON   = 16'd7;
	localparam logic [15:0] CW_ENABLE_OP   = 16'd15;
	localparam logic [15:0] CW_HOME_START  = 16'd31;

	// configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOMING_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MODE = 2'd2;
	localparam logic [15:0]        WAIT_LIMIT_RST    = 16'd5000;
	localparam logic signed [7:0]  HOMING_MODE_RST   = 8'sd6;
	localparam logic signed [7:0]  POSITION_MODE_RST = 8'sd8;
	localparam logic [15:0]        WAIT_COUNT_MAX    = 16'hFFFF;

	typedef struct packed {
		logic [15:0]       wait_limit_ticks;
		logic signed [7:0] homing_mode_code;
		logic signed [7:0] position_mode_code;
	} cfg_t;

	typedef struct packed {
		step_t             seq_step;
		req_t              active_request;
		logic [3:0]        cur_state;
		logic [15:0]       cur_status;
		logic [3:0]        snap_state;
		logic [15:0]       snap_status;
		logic signed [7:0] cur_mode;
		logic signed [7:0] snap_mode;
		logic [15:0]       wait_count;
		logic              homed;
	} seq_state_t;

	typedef struct packed {
		logic              control_valid;
		logic [15:0]       control_word_out;
		logic              mode_valid;
		logic signed [7:0] mode_out;
		logic              reply_valid;
		logic              reply_ok;
		logic [3:0]        drive_state;
		logic              busy_res;
	} result_t;

endpackage

FILE: design/dehs_cmd_if.sv
// ----------------------------------------------------------------------------
// dehs_cmd_if
// event item channel into the sequencer
// ----------------------------------------------------------------------------
interface dehs_cmd_if;
	logic              valid;
	logic              ready;
	logic [2:0]        op;
	logic [15:0]       status_in;
	logic signed [7:0] mode_display;

	modport source (output valid, output op, output status_in, output mode_display,
		input ready);
	modport sink (input valid, input op, input status_in, input mode_display,
		output ready);
endinterface

FILE: design/dehs_res_if.sv
// ----------------------------------------------------------------------------
// dehs_res_if
// result item channel out of the sequencer
// ----------------------------------------------------------------------------
interface dehs_res_if;
	logic              valid;
	logic              ready;
	logic              control_valid;
	logic [15:0]       control_word_out;
	logic              mode_valid;
	logic signed [7:0] mode_out;
	logic              reply_valid;
	logic              reply_ok;
	logic [3:0]        drive_state;
	logic              busy_res;

	modport source (output valid, output control_valid, output control_word_out,
		output mode_valid, output mode_out, output reply_valid, output reply_ok,
		output drive_state, output busy_res, input ready);
	modport sink (input valid, input control_valid, input control_word_out,
		input mode_valid, input mode_out, input reply_valid, input reply_ok,
		input drive_state, input busy_res, output ready);
endinterface

FILE: design/dehs_cfg_if.sv
// ----------------------------------------------------------------------------
// dehs_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface dehs_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [dehs_pkg::CFG_IDX_W-1:0]   index;
	logic [15:0]                      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/drive_enable_homing_sequencer.sv
// ----------------------------------------------------------------------------
// drive_enable_homing_sequencer
// Master-side sequencer for a CiA 402 style drive. Each event item (tick,
// status word, mode display, or a fault reset / homing / position request)
// yields exactly one result item carrying the control word or mode command
// to send, the reply of a finished request, the decoded drive state and the
// busy flag. An item is taken into an input register, evaluated in one pass
// of combinational logic against the sequencer state and written to a result
// register once that register is free or its item is being taken, so the
// block accepts one item per clock cycle while the result sink keeps up.
// The input channel stalls only while the result register holds an item the
// sink has not taken and another item already waits in the input register.
// Requests that arrive while a sequence runs are dropped, and op codes 6 and 7
// change nothing. Configuration writes are always accepted and must only
// occur while idle.
// ----------------------------------------------------------------------------
module drive_enable_homing_sequencer (
	input  logic         clk,
	input  logic         arst_n,
	dehs_cmd_if.sink     cmd,
	dehs_res_if.source   res,
	dehs_cfg_if.sink     cfg
);

	// input register stage
	logic              valid_s1;
	logic [2:0]        op_s1;
	logic [15:0]       status_s1;
	logic signed [7:0] mode_s1;

	// sequencer state and configuration
	dehs_pkg::seq_state_t state_q;
	dehs_pkg::seq_state_t state_nxt;
	dehs_pkg::cfg_t       cfg_q;

	// result register
	logic              res_valid_q;
	dehs_pkg::result_t res_q;
	dehs_pkg::result_t step_res;

	// item in stage one moves on when the result register is free or draining
	logic advance;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_limit_ticks   <= dehs_pkg::WAIT_LIMIT_RST;
			cfg_q.homing_mode_code   <= dehs_pkg::HOMING_MODE_RST;
			cfg_q.position_mode_code <= dehs_pkg::POSITION_MODE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				dehs_pkg::CFG_WAIT_LIMIT:    cfg_q.wait_limit_ticks   <= cfg.data;
				dehs_pkg::CFG_HOMING_MODE:   cfg_q.homing_mode_code   <= signed'(cfg.data[7:0]);
				dehs_pkg::CFG_POSITION_MODE: cfg_q.position_mode_code <= signed'(cfg.data[7:0]);
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1     <= cmd.op;
			status_s1 <= cmd.status_in;
			mode_s1   <= cmd.mode_display;
		end
	end

	// one sequencer step per item
	dehs_step u_step (
		.st           (state_q),
		.cfg          (cfg_q),
		.op           (op_s1),
		.status_in    (status_s1),
		.mode_display (mode_s1),
		.st_nxt       (state_nxt),
		.result       (step_res)
	);

	// sequencer state commits when its item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.seq_step       <= dehs_pkg::ST_IDLE;
			state_q.active_request <= dehs_pkg::REQ_NONE;
			state_q.cur_state      <= dehs_pkg::DS_NOT_READY;
			state_q.cur_status     <= '0;
			state_q.snap_state     <= '0;
			state_q.snap_status    <= '0;
			state_q.cur_mode       <= '0;
			state_q.snap_mode      <= '0;
			state_q.wait_count     <= '0;
			state_q.homed          <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.control_valid    = res_q.control_valid;
	assign res.control_word_out = res_q.control_word_out;
	assign res.mode_valid       = res_q.mode_valid;
	assign res.mode_out         = res_q.mode_out;
	assign res.reply_valid      = res_q.reply_valid;
	assign res.reply_ok         = res_q.reply_ok;
	assign res.drive_state      = res_q.drive_state;
	assign res.busy_res         = res_q.busy_res;

	// a finished request always leaves the sequencer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.reply_valid |-> !res_q.busy_res)
		else $error("reply given while sequence still busy");

	// a control word and a mode command never go out together
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.control_valid && res_q.mode_valid))
		else $error("control word and mode command in one item");

	// idle sequencer holds no request
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.seq_step == dehs_pkg::ST_IDLE |-> state_q.active_request == dehs_pkg::REQ_NONE)
		else $error("request left active while idle");

	// homing done is sticky
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.homed |=> state_q.homed)
		else $error("homed flag cleared");

	// an empty result register never stalls the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> cmd.ready)
		else $error("input stalled with empty result register");

endmodule

FILE: design/dehs_step.sv
// ----------------------------------------------------------------------------
// dehs_step
// combinational step of the sequencer: one item against the current state
// ----------------------------------------------------------------------------
module dehs_step (
	input  dehs_pkg::seq_state_t st,
	input  dehs_pkg::cfg_t       cfg,
	input  logic [2:0]           op,
	input  logic [15:0]          status_in,
	input  logic signed [7:0]    mode_display,
	output dehs_pkg::seq_state_t st_nxt,
	output dehs_pkg::result_t    result
);

	function automatic logic [3:0] decode_state(input logic [15:0] sw);
		logic [15:0] a;
		logic [15:0] b;
		a = sw & dehs_pkg::SW_MASK_A;
		b = sw & dehs_pkg::SW_MASK_B;
		if (a == dehs_pkg::SW_NOT_READY)       return dehs_pkg::DS_NOT_READY;
		else if (a == dehs_pkg::SW_DISABLED)   return dehs_pkg::DS_DISABLED;
		else if (b == dehs_pkg::SW_READY)      return dehs_pkg::DS_READY;
		else if (b == dehs_pkg::SW_ON)         return dehs_pkg::DS_ON;
		else if (b == dehs_pkg::SW_ENABLED)    return dehs_pkg::DS_ENABLED;
		else if (b == dehs_pkg::SW_QUICKSTOP)  return dehs_pkg::DS_QUICKSTOP;
		else if (a == dehs_pkg::SW_FAULT_REAC) return dehs_pkg::DS_FAULT_REAC;
		else if (a == dehs_pkg::SW_FAULT)      return dehs_pkg::DS_FAULT;
		else                                   return dehs_pkg::DS_UNDEFINED;
	endfunction

	logic [3:0]         new_state;
	logic [15:0]        new_status;
	logic signed [7:0]  new_mode;
	logic signed [7:0]  target;
	logic [15:0]        wc_inc;
	logic               cw_step;
	logic               waiting;
	logic               timeout;
	logic               home_ok;
	logic               home_fail;

	dehs_pkg::act_t     act;
	logic               act_ok;
	logic [15:0]        act_word;
	dehs_pkg::step_t    act_step;
	logic               load_req;
	dehs_pkg::req_t     new_req;
	logic               set_homed;
	logic               cw_end;
	logic               cw_ok;

	assign new_status = (op == dehs_pkg::OP_STATUS) ? status_in : st.cur_status;
	assign new_state  = (op == dehs_pkg::OP_STATUS) ? decode_state(status_in) : st.cur_state;
	assign new_mode   = (op == dehs_pkg::OP_MODE) ? mode_display : st.cur_mode;
	assign target     = (st.active_request == dehs_pkg::REQ_HOMING) ?
		cfg.homing_mode_code : cfg.position_mode_code;

	assign wc_inc  = (st.wait_count == dehs_pkg::WAIT_COUNT_MAX) ?
		st.wait_count : st.wait_count + 16'd1;
	assign cw_step = (st.seq_step == dehs_pkg::ST_CW134) || (st.seq_step == dehs_pkg::ST_CW7) ||
		(st.seq_step == dehs_pkg::ST_CW15) || (st.seq_step == dehs_pkg::ST_CW31);
	assign waiting = cw_step || (st.seq_step == dehs_pkg::ST_FR_READY) ||
		(st.seq_step == dehs_pkg::ST_MODE_MSG) || (st.seq_step == dehs_pkg::ST_MODE_CHG);
	assign timeout = (wc_inc >= cfg.wait_limit_ticks);

	assign home_ok   = (new_status & dehs_pkg::SW_HOME_DONE) != 16'd0;
	assign home_fail = ((new_status & dehs_pkg::SW_HOME_ERROR) != 16'd0) ||
		(new_state == dehs_pkg::DS_FAULT);

	// decide what this item does
	always_comb begin
		act       = dehs_pkg::ACT_NONE;
		act_ok    = 1'b0;
		act_word  = '0;
		act_step  = dehs_pkg::ST_IDLE;
		load_req  = 1'b0;
		new_req   = dehs_pkg::REQ_NONE;
		set_homed = 1'b0;
		cw_end    = 1'b0;
		cw_ok     = 1'b0;

		case (op)
			dehs_pkg::OP_TICK: begin
				if (waiting && timeout) begin
					if (cw_step) cw_end = 1'b1;
					else act = dehs_pkg::ACT_FINISH;
				end
			end
			dehs_pkg::OP_STATUS: begin
				if (cw_step) begin
					if (new_state != st.snap_state || new_status != st.snap_status) begin
						cw_end = 1'b1;
						cw_ok  = 1'b1;
					end
				end else if (st.seq_step == dehs_pkg::ST_FR_READY) begin
					if (new_state == dehs_pkg::DS_READY) begin
						act    = dehs_pkg::ACT_FINISH;
						act_ok = 1'b1;
					end
				end else if (st.seq_step == dehs_pkg::ST_HOME) begin
					if (home_ok) begin
						act       = dehs_pkg::ACT_FINISH;
						act_ok    = 1'b1;
						set_homed = 1'b1;
					end else if (home_fail) begin
						act = dehs_pkg::ACT_FINISH;
					end
				end
			end
			dehs_pkg::OP_MODE: begin
				if (st.seq_step == dehs_pkg::ST_MODE_MSG) begin
					if (new_mode == target) begin
						act      = dehs_pkg::ACT_SEND_CW;
						act_word = dehs_pkg::CW_SWITCH_ON;
						act_step = dehs_pkg::ST_CW7;
					end else begin
						act = dehs_pkg::ACT_MODE_CMD;
					end
				end else if (st.seq_step == dehs_pkg::ST_MODE_CHG) begin
					if (new_mode != st.snap_mode) begin
						if (new_mode == target) begin
							act      = dehs_pkg::ACT_SEND_CW;
							act_word = dehs_pkg::CW_SWITCH_ON;
							act_step = dehs_pkg::ST_CW7;
						end else begin
							act = dehs_pkg::ACT_FINISH;
						end
					end
				end
			end
			dehs_pkg::OP_FAULT_RESET: begin
				if (st.seq_step == dehs_pkg::ST_IDLE) begin
					if (new_state != dehs_pkg::DS_FAULT) begin
						act    = dehs_pkg::ACT_FINISH;
						act_ok = 1'b1;
					end else begin
						load_req = 1'b1;
						new_req  = dehs_pkg::REQ_FAULT;
						act      = dehs_pkg::ACT_SEND_CW;
						act_word = dehs_pkg::CW_FAULT_RESET;
						act_step = dehs_pkg::ST_CW134;
					end
				end
			end
			dehs_pkg::OP_HOMING, dehs_pkg::OP_POSITION: begin
				if (st.seq_step == dehs_pkg::ST_IDLE) begin
					if (op == dehs_pkg::OP_POSITION && !st.homed) begin
						act = dehs_pkg::ACT_FINISH;
					end else begin
						load_req = 1'b1;
						new_req  = (op == dehs_pkg::OP_HOMING) ?
							dehs_pkg::REQ_HOMING : dehs_pkg::REQ_POSITION;
						if (new_state == dehs_pkg::DS_READY) begin
							act = dehs_pkg::ACT_ENTER_MODE;
						end else begin
							act      = dehs_pkg::ACT_SEND_CW;
							act_word = dehs_pkg::CW_FAULT_RESET;
							act_step = dehs_pkg::ST_CW134;
						end
					end
				end
			end
			default: ;
		endcase

		// end of a control word wait chains into the next step or finishes the request
		if (cw_end) begin
			if (!cw_ok) begin
				act    = dehs_pkg::ACT_FINISH;
				act_ok = 1'b0;
			end else begin
				case (st.seq_step)
					dehs_pkg::ST_CW134: begin
						if (st.active_request == dehs_pkg::REQ_FAULT) begin
							if (new_state == dehs_pkg::DS_DISABLED) begin
								act = dehs_pkg::ACT_FR_READY;
							end else begin
								act    = dehs_pkg::ACT_FINISH;
								act_ok = (new_state == dehs_pkg::DS_READY);
							end
						end else if (new_state == dehs_pkg::DS_READY ||
							new_state == dehs_pkg::DS_DISABLED) begin
							act = dehs_pkg::ACT_ENTER_MODE;
						end else begin
							act = dehs_pkg::ACT_FINISH;
						end
					end
					dehs_pkg::ST_CW7: begin
						act      = dehs_pkg::ACT_SEND_CW;
						act_word = dehs_pkg::CW_ENABLE_OP;
						act_step = dehs_pkg::ST_CW15;
					end
					dehs_pkg::ST_CW15: begin
						if (st.active_request == dehs_pkg::REQ_HOMING) begin
							act      = dehs_pkg::ACT_SEND_CW;
							act_word = dehs_pkg::CW_HOME_START;
							act_step = dehs_pkg::ST_CW31;
						end else begin
							act    = dehs_pkg::ACT_FINISH;
							act_ok = 1'b1;
						end
					end
					dehs_pkg::ST_CW31: begin
						if (home_ok) begin
							act       = dehs_pkg::ACT_FINISH;
							act_ok    = 1'b1;
							set_homed = 1'b1;
						end else if (home_fail) begin
							act = dehs_pkg::ACT_FINISH;
						end else begin
							act = dehs_pkg::ACT_HOME_WAIT;
						end
					end
					default: begin
						act    = dehs_pkg::ACT_FINISH;
						act_ok = 1'b0;
					end
				endcase
			end
		end
	end

	// next state
	always_comb begin
		st_nxt = st;
		if (op == dehs_pkg::OP_STATUS) begin
			st_nxt.cur_status = new_status;
			st_nxt.cur_state  = new_state;
		end
		if (op == dehs_pkg::OP_MODE) st_nxt.cur_mode = new_mode;
		if (op == dehs_pkg::OP_TICK && waiting) st_nxt.wait_count = wc_inc;
		if (load_req) st_nxt.active_request = new_req;

		case (act)
			dehs_pkg::ACT_FINISH: begin
				st_nxt.seq_step       = dehs_pkg::ST_IDLE;
				st_nxt.active_request = dehs_pkg::REQ_NONE;
			end
			dehs_pkg::ACT_SEND_CW: begin
				st_nxt.snap_state  = new_state;
				st_nxt.snap_status = new_status;
				st_nxt.wait_count  = '0;
				st_nxt.seq_step    = act_step;
			end
			dehs_pkg::ACT_ENTER_MODE: begin
				st_nxt.wait_count = '0;
				st_nxt.seq_step   = dehs_pkg::ST_MODE_MSG;
			end
			dehs_pkg::ACT_FR_READY: begin
				st_nxt.wait_count = '0;
				st_nxt.seq_step   = dehs_pkg::ST_FR_READY;
			end
			dehs_pkg::ACT_MODE_CMD: begin
				st_nxt.snap_mode  = new_mode;
				st_nxt.wait_count = '0;
				st_nxt.seq_step   = dehs_pkg::ST_MODE_CHG;
			end
			dehs_pkg::ACT_HOME_WAIT: begin
				st_nxt.seq_step = dehs_pkg::ST_HOME;
			end
			default: ;
		endcase

		if (set_homed) st_nxt.homed = 1'b1;
	end

	// result fields
	always_comb begin
		result.control_valid    = (act == dehs_pkg::ACT_SEND_CW);
		result.control_word_out = (act == dehs_pkg::ACT_SEND_CW) ? act_word : '0;
		result.mode_valid       = (act == dehs_pkg::ACT_MODE_CMD);
		result.mode_out         = (act == dehs_pkg::ACT_MODE_CMD) ? target : '0;
		result.reply_valid      = (act == dehs_pkg::ACT_FINISH);
		result.reply_ok         = (act == dehs_pkg::ACT_FINISH) && act_ok;
		result.drive_state      = new_state;
		result.busy_res         = (st_nxt.seq_step != dehs_pkg::ST_IDLE);
	end

endmodule
